>>> design/fpba_pkg.sv
// Shared types and constants for the fit-policy block allocator.
package fpba_pkg;

  // Table geometry.
  localparam int unsigned MAX_BLOCKS = 16;
  localparam int unsigned SIZE_BITS  = 16;
  localparam int unsigned IDX_BITS   = $clog2(MAX_BLOCKS);

  // Operation codes of an input item.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  // Placement policy codes; the unused code behaves as first fit.
  localparam logic [1:0] POLICY_FIRST = 2'd0;
  localparam logic [1:0] POLICY_BEST  = 2'd1;
  localparam logic [1:0] POLICY_WORST = 2'd2;

  // Configuration register indexes.
  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_BLOCKS = 1'b1;

  localparam int unsigned CFG_DATA_BITS = 5;

  // Input item fields.
  typedef struct packed {
    logic                 operation;
    logic [IDX_BITS-1:0]  block_select;
    logic [SIZE_BITS-1:0] size_value;
  } alloc_req_t;

  // Result item fields.
  typedef struct packed {
    logic                 granted;
    logic [IDX_BITS-1:0]  chosen_block;
    logic [SIZE_BITS-1:0] space_left;
  } alloc_rsp_t;

  // Compare mode broadcast to every cell during a scan.
  typedef struct packed {
    logic pick_min;
    logic pick_max;
  } scan_mode_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

endpackage

>>> design/fit_policy_block_allocator_unit.sv
// Fit-policy block allocator: controller and a chain of block cells.
// A load item's result strobe is high in the cycle after the accepting edge.
// An allocate item walks a candidate through MAX_BLOCKS cells, one per cycle, then updates
// the chosen block in ST_UPDATE. Busy spans the scan and the update; the result strobe is high
// in the cycle after the update; busy holds off the next item. Results cannot be stalled.
// Reset sets first fit and sixteen blocks in use; block sizes are undefined until loaded.
module fit_policy_block_allocator_unit
  import fpba_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                     start,
  input  alloc_req_t               in_i,
  output logic                     busy,
  output logic                     done_o,
  output alloc_rsp_t               out_o
);

  localparam int unsigned IW = IDX_BITS;
  localparam int unsigned CW = (IW > 5) ? IW : 5;

  state_e               state_q, state_d;
  logic [IW-1:0]        cnt_q, cnt_d;
  logic [1:0]           policy_q;
  logic [4:0]           blocks_q;
  logic                 accept;
  logic                 sel_ok;
  logic [SIZE_BITS-1:0] launch_req_q;
  scan_mode_t           mode;
  logic [MAX_BLOCKS-1:0] active;

  logic                 wr_en;
  logic [IW-1:0]        wr_idx;
  logic [SIZE_BITS-1:0] wr_val;
  logic [SIZE_BITS-1:0] left;
  logic                 keep_rest;

  logic                 done_d;
  alloc_rsp_t           out_d;

  logic [SIZE_BITS-1:0] req_c   [MAX_BLOCKS+1];
  logic                 found_c [MAX_BLOCKS+1];
  logic [SIZE_BITS-1:0] best_c  [MAX_BLOCKS+1];
  logic [IW-1:0]        pick_c  [MAX_BLOCKS+1];

  assign accept = start && !busy;
  assign sel_ok = (32'(in_i.block_select) < MAX_BLOCKS);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POLICY_FIRST;
      blocks_q <= 5'd16;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_POLICY: policy_q <= cfg_data_i[1:0];
        REG_BLOCKS: blocks_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  assign mode.pick_min = (policy_q == POLICY_BEST);
  assign mode.pick_max = (policy_q == POLICY_WORST);
  assign keep_rest     = !mode.pick_min && !mode.pick_max;

  // Which cells take part in the search; counts above the table saturate.
  always_comb begin
    for (int j = 0; j < MAX_BLOCKS; j++) begin
      active[j] = (CW'(blocks_q) > CW'(j));
    end
  end

  // Request size captured at accept; it feeds the head of the chain.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      launch_req_q <= in_i.size_value;
    end
  end

  assign req_c[0]   = launch_req_q;
  assign found_c[0] = 1'b0;
  assign best_c[0]  = '0;
  assign pick_c[0]  = '0;

  // The cell chain.
  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    fpba_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i    (clk_i),
      .mode_i   (mode),
      .active_i (active[g]),
      .wr_en_i  (wr_en),
      .wr_idx_i (wr_idx),
      .wr_val_i (wr_val),
      .req_i    (req_c[g]),
      .found_i  (found_c[g]),
      .best_i   (best_c[g]),
      .pick_i   (pick_c[g]),
      .req_o    (req_c[g+1]),
      .found_o  (found_c[g+1]),
      .best_o   (best_c[g+1]),
      .pick_o   (pick_c[g+1])
    );
  end

  // Space left in the chosen block once the scan is finished; zero under best and worst fit.
  assign left = keep_rest ? (best_c[MAX_BLOCKS] - req_c[MAX_BLOCKS]) : '0;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (in_i.operation == OP_ALLOC)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_q == IW'(MAX_BLOCKS - 1)) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Output logic: block write port, scan counter and result.
  always_comb begin
    wr_en  = 1'b0;
    wr_idx = IW'(in_i.block_select);
    wr_val = in_i.size_value;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    out_d  = '0;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          done_d = (in_i.operation == OP_LOAD);
          wr_en  = (in_i.operation == OP_LOAD) && sel_ok;
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + 1'b1;
      end
      ST_UPDATE: begin
        wr_en  = found_c[MAX_BLOCKS];
        wr_idx = pick_c[MAX_BLOCKS];
        wr_val = left;
        done_d = 1'b1;
        if (found_c[MAX_BLOCKS]) begin
          out_d.granted      = 1'b1;
          out_d.chosen_block = pick_c[MAX_BLOCKS];
          out_d.space_left   = left;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_o  <= done_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    out_o <= out_d;
  end

  assign busy = (state_q != ST_IDLE);

  // An update cycle always delivers a result in the next cycle.
  a_update_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE) |=> done_o)
    else $error("update cycle produced no result");

  // A grant only comes out of an update cycle.
  a_grant_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_o.granted) |-> $past(state_q == ST_UPDATE))
    else $error("grant without a finished scan");

  // The scan runs through the whole chain before updating.
  a_scan_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> ##(MAX_BLOCKS) (state_q == ST_UPDATE))
    else $error("scan length differs from chain length");

  // A refused or load item reports no block and no space.
  a_no_grant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !out_o.granted) |-> (out_o.chosen_block == '0 && out_o.space_left == '0))
    else $error("non-granted result carries data");

endmodule

>>> design/fpba_cell.sv
// One block cell: holds a free size and refines the passing search candidate.
module fpba_cell
  import fpba_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  logic                 clk_i,
  input  scan_mode_t           mode_i,
  input  logic                 active_i,
  input  logic                 wr_en_i,
  input  logic [IDX_BITS-1:0]  wr_idx_i,
  input  logic [SIZE_BITS-1:0] wr_val_i,
  input  logic [SIZE_BITS-1:0] req_i,
  input  logic                 found_i,
  input  logic [SIZE_BITS-1:0] best_i,
  input  logic [IDX_BITS-1:0]  pick_i,
  output logic [SIZE_BITS-1:0] req_o,
  output logic                 found_o,
  output logic [SIZE_BITS-1:0] best_o,
  output logic [IDX_BITS-1:0]  pick_o
);

  logic [SIZE_BITS-1:0] size_q;
  logic                 fits;
  logic                 take;

  // Block size storage, written by loads and by the post-scan update.
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_idx_i == IDX_BITS'(IDX))) begin
      size_q <= wr_val_i;
    end
  end

  // Decide whether this block replaces the candidate carried so far.
  always_comb begin
    fits = active_i && (size_q >= req_i);
    if (mode_i.pick_min) begin
      take = fits && (!found_i || (size_q < best_i));
    end else if (mode_i.pick_max) begin
      take = fits && (!found_i || (size_q > best_i));
    end else begin
      take = fits && !found_i;
    end
  end

  // Hand the candidate to the next cell.
  always_ff @(posedge clk_i) begin
    req_o   <= req_i;
    found_o <= found_i || take;
    best_o  <= take ? size_q : best_i;
    pick_o  <= take ? IDX_BITS'(IDX) : pick_i;
  end

endmodule
